// ===== hw/rtl/erfsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erfsd_pkg
// Shared types and constants for the echo range filter and segment display.
// ----------------------------------------------------------------------------
package erfsd_pkg;

	// item opcodes
	localparam logic OP_MEASURE = 1'b0;
	localparam logic OP_SCAN    = 1'b1;

	// active-low digit selects
	localparam logic [2:0] EN_ONES     = 3'd5;
	localparam logic [2:0] EN_TENS     = 3'd6;
	localparam logic [2:0] EN_HUNDREDS = 3'd3;
	localparam logic [2:0] EN_NONE     = 3'd7;

	// scan positions
	localparam logic [1:0] POS_ONES     = 2'd0;
	localparam logic [1:0] POS_TENS     = 2'd1;
	localparam logic [1:0] POS_HUNDREDS = 2'd2;

	// distance limits
	localparam logic [9:0]  DIST_MAX      = 10'd999;
	// smallest echo count whose distance count*12/58 exceeds the limit
	localparam logic [15:0] COUNT_SAT     = 16'd4834;
	// 6 * ceil(2^20 / 29): count*12/58 == (count * RECIP_6_29) >> 20 below saturation
	localparam logic [17:0] RECIP_6_29    = 18'd216948;
	// digit split reciprocals: /100 as *41 >> 12, /10 as *103 >> 10
	localparam logic [5:0]  RECIP_100     = 6'd41;
	localparam logic [6:0]  RECIP_10      = 7'd103;

	// stage-one result passed to the filter stage
	typedef struct packed {
		logic       opcode;
		logic       echo_seen;
		logic [9:0] dist_cm;
	} meas_t;

	// active-low seven-segment pattern of a decimal digit
	function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
		logic [7:0] pat;
		case (digit)
			4'd0:    pat = 8'hC0;
			4'd1:    pat = 8'hF9;
			4'd2:    pat = 8'hA4;
			4'd3:    pat = 8'hB0;
			4'd4:    pat = 8'h99;
			4'd5:    pat = 8'h92;
			4'd6:    pat = 8'h82;
			4'd7:    pat = 8'hF8;
			4'd8:    pat = 8'h80;
			default: pat = 8'h90;
		endcase
		return pat;
	endfunction

endpackage

// ===== hw/rtl/erfsd_dist.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erfsd_dist
// Input register and echo count to distance conversion with saturation.
// ----------------------------------------------------------------------------
module erfsd_dist import erfsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [15:0] echo_count,
	input  logic        echo_seen,
	output logic        meas_valid,
	input  logic        meas_ready,
	output meas_t       meas
);

	logic        valid_s1;
	logic        opcode_s1;
	logic [15:0] count_s1;
	logic        seen_s1;
	logic        valid_s2;
	meas_t       meas_s2;
	logic        adv_s1;
	logic        ready_s2;
	logic [30:0] prod;
	logic [9:0]  dist_cm;

	assign ready_s2 = !valid_s2 || meas_ready;
	assign adv_s1   = valid_s1 && ready_s2;
	assign in_stall = valid_s1 && !ready_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			opcode_s1 <= opcode;
			count_s1  <= echo_count;
			seen_s1   <= echo_seen;
		end
	end

	// distance = count*12/58 by reciprocal, saturated, zero without echo
	assign prod = count_s1[12:0] * RECIP_6_29;

	always_comb begin
		if (!seen_s1) begin
			dist_cm = 10'd0;
		end else if (count_s1 >= COUNT_SAT) begin
			dist_cm = DIST_MAX;
		end else begin
			dist_cm = prod[29:20];
		end
	end

	// conversion result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			meas_s2.opcode    <= opcode_s1;
			meas_s2.echo_seen <= seen_s1;
			meas_s2.dist_cm   <= dist_cm;
		end
	end

	assign meas_valid = valid_s2;
	assign meas       = meas_s2;

endmodule

// ===== hw/rtl/erfsd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erfsd_core
// Change filter, digit latch, display scan and result register.
// ----------------------------------------------------------------------------
module erfsd_core import erfsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [3:0] threshold,
	input  logic       meas_valid,
	output logic       meas_ready,
	input  meas_t      meas,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] segment_pattern,
	output logic [2:0] digit_enable,
	output logic [9:0] shown_distance,
	output logic [9:0] latest_distance,
	output logic       timeout_indicator
);

	logic       out_valid_q;
	logic [9:0] shown_q;
	logic [9:0] latest_q;
	logic [3:0] count_q;
	logic [7:0] digit_q [3];
	logic [1:0] pos_q;
	logic       ind_q;
	logic [7:0] pattern_q;
	logic [2:0] enable_q;
	logic       adv;

	logic [15:0] h_prod;
	logic [3:0]  hund;
	logic [6:0]  rem;
	logic [13:0] t_prod;
	logic [3:0]  tens;
	logic [3:0]  ones;
	logic [3:0]  count_inc;
	logic        take;

	assign meas_ready = !out_valid_q || !out_stall;
	assign adv        = meas_valid && meas_ready;

	// decimal split of the new reading
	assign h_prod = meas.dist_cm * RECIP_100;
	assign hund   = h_prod[15:12];
	assign rem    = 7'(meas.dist_cm - 10'(hund) * 10'd100);
	assign t_prod = rem * RECIP_10;
	assign tens   = t_prod[13:10];
	assign ones   = 4'(rem - 7'(tens) * 7'd10);

	// change filter
	always_comb begin
		if (meas.dist_cm == shown_q) begin
			count_inc = 4'd0;
		end else if (count_q != 4'd15) begin
			count_inc = count_q + 4'd1;
		end else begin
			count_inc = count_q;
		end
		take = (count_inc >= threshold);
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (meas_ready) begin
			out_valid_q <= meas_valid;
		end
	end

	// filter, digit and scan state; these registers are also the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_q    <= 10'd0;
			latest_q   <= 10'd0;
			count_q    <= 4'd0;
			digit_q[0] <= 8'd0;
			digit_q[1] <= 8'd0;
			digit_q[2] <= 8'd0;
			pos_q      <= POS_ONES;
			ind_q      <= 1'b0;
			pattern_q  <= 8'd0;
			enable_q   <= EN_NONE;
		end else if (adv) begin
			if (meas.opcode == OP_MEASURE) begin
				latest_q <= meas.dist_cm;
				if (!meas.echo_seen) begin
					ind_q <= ~ind_q;
				end
				if (take) begin
					count_q    <= 4'd0;
					shown_q    <= meas.dist_cm;
					digit_q[0] <= seg_pattern(ones);
					digit_q[1] <= seg_pattern(tens);
					digit_q[2] <= seg_pattern(hund);
				end else begin
					count_q <= count_inc;
				end
			end else begin
				unique case (pos_q)
					POS_TENS: begin
						pattern_q <= digit_q[1];
						enable_q  <= EN_TENS;
						pos_q     <= POS_HUNDREDS;
					end
					POS_HUNDREDS: begin
						pattern_q <= digit_q[2];
						enable_q  <= EN_HUNDREDS;
						pos_q     <= POS_ONES;
					end
					default: begin
						pattern_q <= digit_q[0];
						enable_q  <= EN_ONES;
						pos_q     <= POS_TENS;
					end
				endcase
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign segment_pattern   = pattern_q;
	assign digit_enable      = enable_q;
	assign shown_distance    = shown_q;
	assign latest_distance   = latest_q;
	assign timeout_indicator = ind_q;

endmodule

// ===== hw/rtl/echo_range_filter_seg_display.sv =====
`timescale 1ns / 1ps
// An accepted item passes the input register, the distance register and
// the result register in that order before its result is valid.
// Throughput: one item per cycle while out_stall is low; the distance stage
// holds a single constant multiply and the result stage the filter update.
// Reset: all filter and display state clears, digit select reads no digit,
// change threshold returns to 3.
// ----------------------------------------------------------------------------
// echo_range_filter_seg_display
// Ultrasonic echo to distance conversion with a change filter and a
// three-digit multiplexed seven-segment display driver.
// ----------------------------------------------------------------------------
module echo_range_filter_seg_display import erfsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [15:0] echo_count,
	input  logic        echo_seen,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  segment_pattern,
	output logic [2:0]  digit_enable,
	output logic [9:0]  shown_distance,
	output logic [9:0]  latest_distance,
	output logic        timeout_indicator
);

	logic [3:0] threshold_q;
	logic       meas_valid;
	logic       meas_ready;
	meas_t      meas;

	// threshold register, written by a config transaction
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= 4'd3;
		end else if (cfg_valid && cfg_ready) begin
			threshold_q <= cfg_data;
		end
	end

	erfsd_dist u_dist (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.echo_count (echo_count),
		.echo_seen  (echo_seen),
		.meas_valid (meas_valid),
		.meas_ready (meas_ready),
		.meas       (meas)
	);

	erfsd_core u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.threshold         (threshold_q),
		.meas_valid        (meas_valid),
		.meas_ready        (meas_ready),
		.meas              (meas),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.segment_pattern   (segment_pattern),
		.digit_enable      (digit_enable),
		.shown_distance    (shown_distance),
		.latest_distance   (latest_distance),
		.timeout_indicator (timeout_indicator)
	);

endmodule

// ===== dv/tb_echo_range_filter_seg_display.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_echo_range_filter_seg_display
// Self-checking bench for the echo range filter and segment display. It sends
// measurement and scan transactions in random bursts against a randomly
// stalling receiver. A scoreboard predicts distance, filter and display state
// for every accepted transaction and compares each returned result in order.
// ----------------------------------------------------------------------------
module tb_echo_range_filter_seg_display;
	import erfsd_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_ITEMS   = 230;

	// active-low segment codes for digits 0..9
	localparam logic [7:0] SEG_CODE [10] = '{
		8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
	};

	typedef struct {
		logic        opcode;
		logic [15:0] count;
		logic        seen;
	} range_item_t;

	typedef struct {
		logic [7:0] pattern;
		logic [2:0] enable;
		logic [9:0] shown;
		logic [9:0] latest;
		logic       indicator;
	} display_state_t;

	// predicts the display state after each transaction and checks results
	class range_scoreboard;
		logic [3:0]     threshold;
		logic [9:0]     shown_cm;
		logic [9:0]     latest_cm;
		logic [3:0]     diff_run;
		logic [7:0]     digit_seg [3];
		logic [1:0]     scan_pos;
		logic           timeout_level;
		logic [7:0]     drive_seg;
		logic [2:0]     drive_en;
		display_state_t expected_q [$];
		int             mismatches;

		function new();
			threshold     = 4'd3;
			shown_cm      = '0;
			latest_cm     = '0;
			diff_run      = '0;
			digit_seg     = '{8'h00, 8'h00, 8'h00};
			scan_pos      = POS_ONES;
			timeout_level = 1'b0;
			drive_seg     = '0;
			drive_en      = EN_NONE;
			mismatches    = 0;
		endfunction

		function void set_threshold(logic [3:0] value);
			threshold = value;
		endfunction

		// count*12/58 at full width, clipped to the display range
		function logic [9:0] echo_to_cm(logic [15:0] count);
			logic [31:0] product;
			product = 32'(count) * 32'd12;
			product = product / 32'd58;
			if (product > 32'd999)
				return DIST_MAX;
			return product[9:0];
		endfunction

		function void apply_measurement(logic [15:0] count, logic seen);
			int hundreds;
			int tens;
			int ones;
			if (seen) begin
				latest_cm = echo_to_cm(count);
			end else begin
				latest_cm = '0;
				timeout_level = ~timeout_level;
			end
			// change filter
			if (latest_cm == shown_cm)
				diff_run = '0;
			else if (diff_run != 4'd15)
				diff_run = diff_run + 4'd1;
			if (diff_run >= threshold) begin
				diff_run = '0;
				shown_cm = latest_cm;
				hundreds = int'(shown_cm) / 100;
				tens     = (int'(shown_cm) % 100) / 10;
				ones     = int'(shown_cm) % 10;
				if (hundreds > 9)
					hundreds = 9;
				digit_seg[0] = SEG_CODE[ones];
				digit_seg[1] = SEG_CODE[tens];
				digit_seg[2] = SEG_CODE[hundreds];
			end
		endfunction

		function void apply_scan();
			case (scan_pos)
				POS_TENS: begin
					drive_seg = digit_seg[1];
					drive_en  = EN_TENS;
					scan_pos  = POS_HUNDREDS;
				end
				POS_HUNDREDS: begin
					drive_seg = digit_seg[2];
					drive_en  = EN_HUNDREDS;
					scan_pos  = POS_ONES;
				end
				default: begin
					drive_seg = digit_seg[0];
					drive_en  = EN_ONES;
					scan_pos  = POS_TENS;
				end
			endcase
		endfunction

		function void note_item(range_item_t item);
			display_state_t want;
			if (item.opcode == OP_MEASURE)
				apply_measurement(item.count, item.seen);
			else
				apply_scan();
			want.pattern   = drive_seg;
			want.enable    = drive_en;
			want.shown     = shown_cm;
			want.latest    = latest_cm;
			want.indicator = timeout_level;
			expected_q.push_back(want);
		endfunction

		function void check_result(display_state_t got);
			display_state_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing expected: seg %h en %0d shown %0d latest %0d ind %0d",
						$time, got.pattern, got.enable, got.shown, got.latest, got.indicator);
				return;
			end
			want = expected_q.pop_front();
			if (got.pattern !== want.pattern || got.enable !== want.enable ||
					got.shown !== want.shown || got.latest !== want.latest ||
					got.indicator !== want.indicator) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch exp seg %h en %0d shown %0d latest %0d ind %0d, got seg %h en %0d shown %0d latest %0d ind %0d",
						$time, want.pattern, want.enable, want.shown, want.latest, want.indicator,
						got.pattern, got.enable, got.shown, got.latest, got.indicator);
			end
		endfunction
	endclass

	logic        clk               = 1'b0;
	logic        arst_n            = 1'b0;
	logic        cfg_valid         = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_data          = '0;
	logic        in_valid          = 1'b0;
	logic        in_stall;
	logic        opcode            = OP_MEASURE;
	logic [15:0] echo_count        = '0;
	logic        echo_seen         = 1'b0;
	logic        out_valid;
	logic        out_stall         = 1'b0;
	logic [7:0]  segment_pattern;
	logic [2:0]  digit_enable;
	logic [9:0]  shown_distance;
	logic [9:0]  latest_distance;
	logic        timeout_indicator;

	range_scoreboard sb;
	range_item_t     stim_q [$];
	range_item_t     driven_item;
	int              burst_left  = 1;
	int              gap_left    = 0;
	int              stall_mode  = 0;
	int              stall_hold  = 0;
	int unsigned     cycle_count = 0;

	echo_range_filter_seg_display DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.opcode            (opcode),
		.echo_count        (echo_count),
		.echo_seen         (echo_seen),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.segment_pattern   (segment_pattern),
		.digit_enable      (digit_enable),
		.shown_distance    (shown_distance),
		.latest_distance   (latest_distance),
		.timeout_indicator (timeout_indicator)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// input side: bursts of transactions separated by random gaps
	always @(posedge clk) begin : drive_items
		range_item_t next_item;
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_item(driven_item);
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (stim_q.size() > 0) begin
					next_item   = stim_q.pop_front();
					driven_item = next_item;
					in_valid   <= 1'b1;
					opcode     <= next_item.opcode;
					echo_count <= next_item.count;
					echo_seen  <= next_item.seen;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output side: check results, stall in changing patterns
	always @(posedge clk) begin : take_results
		display_state_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.pattern   = segment_pattern;
				got.enable    = digit_enable;
				got.shown     = shown_distance;
				got.latest    = latest_distance;
				got.indicator = timeout_indicator;
				sb.check_result(got);
			end
			if (stall_hold == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_hold = $urandom_range(20, 300);
			end else begin
				stall_hold--;
			end
			case (stall_mode)
				0:       out_stall <= 1'b0;
				1:       out_stall <= ($urandom_range(0, 3) == 0);
				2:       out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= cycle_count[2];
			endcase
		end
	end

	task automatic push_item(logic op, logic [15:0] count, logic seen);
		range_item_t item;
		item.opcode = op;
		item.count  = count;
		item.seen   = seen;
		stim_q.push_back(item);
	endtask

	// wait until every queued transaction is sent and every result returned
	task automatic wait_drained();
		do
			@(posedge clk);
		while (stim_q.size() != 0 || in_valid || sb.expected_q.size() != 0);
	endtask

	task automatic write_threshold(logic [3:0] value);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_threshold(value);
	endtask

	// runs of similar readings so the filter updates, mixed with scans and noise
	task automatic random_items(int n, int threshold);
		int          made;
		int          run;
		logic [15:0] base;
		made = 0;
		while (made < n) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					push_item(OP_SCAN, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
					made++;
				end
				3: begin
					push_item(OP_MEASURE, 16'($urandom_range(0, 65535)),
						1'($urandom_range(0, 1)));
					made++;
				end
				default: begin
					if ($urandom_range(0, 9) == 0)
						base = 16'($urandom_range(0, 65535));
					else
						base = 16'($urandom_range(0, 5000));
					run = $urandom_range(1, threshold + 3);
					repeat (run) begin
						push_item(OP_MEASURE, base + 16'($urandom_range(0, 3)),
							$urandom_range(0, 7) != 0);
						made++;
						if ($urandom_range(0, 3) == 0) begin
							push_item(OP_SCAN, 16'($urandom_range(0, 65535)),
								1'($urandom_range(0, 1)));
							made++;
						end
					end
				end
			endcase
		end
	endtask

	initial begin : main_sequence
		int phase_threshold [8];
		phase_threshold = '{1, 15, 0, 6, 2, 11, 3, 15};
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// scans straight after reset drive the cleared all-zero digit patterns (all segments lit)
		push_item(OP_SCAN, 16'hFFFF, 1'b1);
		push_item(OP_SCAN, 16'hFFFF, 1'b1);
		push_item(OP_SCAN, 16'hFFFF, 1'b1);
		// zero reading equals the shown value
		push_item(OP_MEASURE, 16'h0000, 1'b1);
		// full-scale count saturates and updates after three readings
		push_item(OP_MEASURE, 16'hFFFF, 1'b1);
		push_item(OP_MEASURE, 16'hFFFF, 1'b1);
		push_item(OP_MEASURE, 16'hFFFF, 1'b1);
		push_item(OP_SCAN, 16'h0000, 1'b0);
		push_item(OP_SCAN, 16'h0000, 1'b0);
		push_item(OP_SCAN, 16'h0000, 1'b0);
		// either side of the saturation point
		push_item(OP_MEASURE, 16'd4833, 1'b1);
		push_item(OP_MEASURE, 16'd4834, 1'b1);
		// missing echo reads zero and toggles the indicator
		push_item(OP_MEASURE, 16'hFFFF, 1'b0);
		push_item(OP_MEASURE, 16'hFFFF, 1'b0);
		push_item(OP_MEASURE, 16'hFFFF, 1'b0);
		// a differing reading then equal ones clear the count
		push_item(OP_MEASURE, 16'd290, 1'b1);
		push_item(OP_MEASURE, 16'd291, 1'b1);
		push_item(OP_MEASURE, 16'd0, 1'b0);
		push_item(OP_MEASURE, 16'd1, 1'b1);
		push_item(OP_SCAN, 16'h5A5A, 1'b0);
		push_item(OP_SCAN, 16'hA5A5, 1'b1);

		// threshold lowered below a count already built up
		write_threshold(4'd15);
		repeat (4) push_item(OP_MEASURE, 16'd1450, 1'b1);
		write_threshold(4'd2);
		push_item(OP_MEASURE, 16'd1450, 1'b1);

		// random phases over a range of thresholds, extremes included
		foreach (phase_threshold[i]) begin
			write_threshold(4'(phase_threshold[i]));
			random_items(PHASE_ITEMS, phase_threshold[i]);
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
